### design/glps_pkg.sv
// Shared types and constants for the grid line point stepper.
`default_nettype none

package glps_pkg;

   // Default widths for coordinates and the fraction-done value
   localparam int COORD_BITS_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 16;

   // Request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAC_DIV,
      ST_EMIT,
      ST_PROD,
      ST_OFF_LOAD,
      ST_OFF_DIV,
      ST_OFF_APPLY
   } glps_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_line;
      logic frac_start;
      logic off_start;
      logic div_step;
      logic emit;
      logic advance;
      logic prod_capture;
      logic off_apply;
   } glps_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic span_zero;
      logic at_end;
   } glps_status_type;

endpackage

`default_nettype wire

### design/glps_div.sv
// Restoring divider, one quotient bit per cycle while step is high, with round-to-nearest-even result.
`default_nettype none

module glps_div #(
   parameter int DW = glps_pkg::COORD_BITS_DEF + 1,
   parameter int QW = glps_pkg::COORD_BITS_DEF + 1
) (
   input  wire logic          clock,
   input  wire logic          load,
   input  wire logic          step,
   input  wire logic [DW-1:0] divisor,
   input  wire logic [DW-1:0] rem_init,
   input  wire logic [QW-1:0] num_init,
   output logic      [QW-1:0] quotient
);

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] num_ff, num_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [DW:0]   trial;
   logic [DW+1:0] diff;
   logic          ge;
   logic [DW:0]   twice;
   logic          round_up;

   // Trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      trial = {rem_ff, num_ff[QW-1]};
      diff  = {1'b0, trial} - {2'b00, divisor};
      ge    = ~diff[DW+1];
   end

   // Load operands, advance one bit, or hold
   always_comb begin
      priority if (load) begin
         rem_in  = rem_init;
         num_in  = num_init;
         quot_in = '0;
      end else if (step) begin
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         num_in  = num_ff << 1;
         quot_in = {quot_ff[QW-2:0], ge};
      end else begin
         rem_in  = rem_ff;
         num_in  = num_ff;
         quot_in = quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   // Round to nearest, ties to even, from the final remainder
   always_comb begin
      twice    = {rem_ff, 1'b0};
      round_up = (twice > {1'b0, divisor}) || ((twice == {1'b0, divisor}) && quot_ff[0]);
      quotient = quot_ff + QW'(round_up);
   end

endmodule

`default_nettype wire

### design/glps_ctrl.sv
// Controller state machine: sequences the load, fraction, emit, advance and minor offset steps.
`default_nettype none

module glps_ctrl #(
   parameter int FW     = glps_pkg::FRACTION_BITS_DEF + 1,
   parameter int SPAN_W = glps_pkg::COORD_BITS_DEF + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_operation,
   output logic                        req_stall,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   input  wire glps_pkg::glps_status_type status,
   output glps_pkg::glps_cmd_type      cmd
);

   localparam int QW    = (FW > SPAN_W) ? FW : SPAN_W;
   localparam int CNT_W = $clog2(QW);
   localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FW - 1);
   localparam logic [CNT_W-1:0] OFF_LAST  = CNT_W'(SPAN_W - 1);

   glps_pkg::glps_state_type state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_stall    = (state_ff != glps_pkg::ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_free     = !rsp_valid_ff || !rsp_stall;
      unique case (state_ff)
         glps_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  glps_pkg::OP_LOAD: begin
                     cmd.load_line = 1'b1;
                  end
                  glps_pkg::OP_NEXT: begin
                     if (status.span_zero) begin
                        state_in = glps_pkg::ST_EMIT;
                     end else begin
                        cmd.frac_start = 1'b1;
                        cnt_in         = '0;
                        state_in       = glps_pkg::ST_FRAC_DIV;
                     end
                  end
               endcase
            end
         end
         glps_pkg::ST_FRAC_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == FRAC_LAST) begin
               state_in = glps_pkg::ST_EMIT;
            end
         end
         glps_pkg::ST_EMIT: begin
            // Wait for the output register, then step the major axis unless at the end
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.at_end) begin
                  state_in = glps_pkg::ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = status.span_zero ? glps_pkg::ST_OFF_APPLY : glps_pkg::ST_PROD;
               end
            end
         end
         glps_pkg::ST_PROD: begin
            cmd.prod_capture = 1'b1;
            state_in         = glps_pkg::ST_OFF_LOAD;
         end
         glps_pkg::ST_OFF_LOAD: begin
            cmd.off_start = 1'b1;
            cnt_in        = '0;
            state_in      = glps_pkg::ST_OFF_DIV;
         end
         glps_pkg::ST_OFF_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == OFF_LAST) begin
               state_in = glps_pkg::ST_OFF_APPLY;
            end
         end
         glps_pkg::ST_OFF_APPLY: begin
            cmd.off_apply = 1'b1;
            state_in      = glps_pkg::ST_IDLE;
         end
         default: begin
            state_in = glps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= glps_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### design/glps_dp.sv
// Datapath: line registers, major/minor stepping, multiplier, divider and output register.
`default_nettype none

module glps_dp #(
   parameter int COORD_BITS    = glps_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = glps_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire glps_pkg::glps_cmd_type        cmd,
   input  wire logic signed [COORD_BITS-1:0]  req_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_end_y,
   output glps_pkg::glps_status_type          status,
   output logic signed [COORD_BITS-1:0]       rsp_point_x,
   output logic signed [COORD_BITS-1:0]       rsp_point_y,
   output logic        [FRACTION_BITS:0]      rsp_fraction_done,
   output logic                               rsp_more_points
);

   localparam int SPAN_W = COORD_BITS + 1;
   localparam int FW     = FRACTION_BITS + 1;
   localparam int QW     = (FW > SPAN_W) ? FW : SPAN_W;
   localparam int PROD_W = 2 * SPAN_W;
   localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   logic signed [COORD_BITS-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [COORD_BITS-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                         major_x_ff, major_x_in;
   logic                         step_neg_ff, step_neg_in;
   logic                         mi_neg_ff, mi_neg_in;
   logic [SPAN_W-1:0]            span_ff, span_in;
   logic [SPAN_W-1:0]            mi_mag_ff, mi_mag_in;
   logic [SPAN_W-1:0]            k_ff, k_in;
   logic [PROD_W-1:0]            prod_ff;

   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [FW-1:0]                rsp_frac_ff;
   logic                         rsp_more_ff;

   logic signed [SPAN_W-1:0]     dx, dy;
   logic [SPAN_W-1:0]            adx, ady;
   logic                         load_major_x;
   logic signed [COORD_BITS-1:0] ma_cur, ma_next, mi_start, mi_new;
   logic [SPAN_W-1:0]            off;
   logic                         span_zero, at_end;

   logic                         div_load;
   logic [SPAN_W-1:0]            div_rem_init;
   logic [QW-1:0]                div_num_init;
   logic [QW-1:0]                div_result;

   // Endpoint deltas and major axis choice for a load
   always_comb begin
      dx           = SPAN_W'(req_end_x) - SPAN_W'(req_start_x);
      dy           = SPAN_W'(req_end_y) - SPAN_W'(req_start_y);
      adx          = dx[SPAN_W-1] ? $unsigned(-dx) : $unsigned(dx);
      ady          = dy[SPAN_W-1] ? $unsigned(-dy) : $unsigned(dy);
      load_major_x = (dy == '0) || (adx > ady);
   end

   // Major step and minor placement from the stored line
   always_comb begin
      ma_cur    = major_x_ff ? cur_x_ff : cur_y_ff;
      mi_start  = major_x_ff ? start_y_ff : start_x_ff;
      ma_next   = step_neg_ff ? (ma_cur - COORD_BITS'(1)) : (ma_cur + COORD_BITS'(1));
      span_zero = (span_ff == '0);
      off       = span_zero ? '0 : div_result[SPAN_W-1:0];
      mi_new    = mi_neg_ff ? (mi_start - off[COORD_BITS-1:0])
                            : (mi_start + off[COORD_BITS-1:0]);
      at_end    = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   end

   assign status.span_zero = span_zero;
   assign status.at_end    = at_end;

   // Next values of the line state
   always_comb begin
      start_x_in  = start_x_ff;
      start_y_in  = start_y_ff;
      end_x_in    = end_x_ff;
      end_y_in    = end_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      major_x_in  = major_x_ff;
      step_neg_in = step_neg_ff;
      mi_neg_in   = mi_neg_ff;
      span_in     = span_ff;
      mi_mag_in   = mi_mag_ff;
      k_in        = k_ff;
      priority if (cmd.load_line) begin
         start_x_in  = req_start_x;
         start_y_in  = req_start_y;
         end_x_in    = req_end_x;
         end_y_in    = req_end_y;
         cur_x_in    = req_start_x;
         cur_y_in    = req_start_y;
         major_x_in  = load_major_x;
         step_neg_in = load_major_x ? (req_end_x < req_start_x) : (req_end_y < req_start_y);
         span_in     = load_major_x ? adx : ady;
         mi_mag_in   = load_major_x ? ady : adx;
         mi_neg_in   = load_major_x ? dy[SPAN_W-1] : dx[SPAN_W-1];
         k_in        = '0;
      end else if (cmd.advance) begin
         if (major_x_ff) begin
            cur_x_in = ma_next;
         end else begin
            cur_y_in = ma_next;
         end
         k_in = k_ff + SPAN_W'(1);
      end else if (cmd.off_apply) begin
         if (major_x_ff) begin
            cur_y_in = mi_new;
         end else begin
            cur_x_in = mi_new;
         end
      end else begin
         // Hold the line state
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         end_x_ff    <= '0;
         end_y_ff    <= '0;
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         major_x_ff  <= 1'b1;
         step_neg_ff <= 1'b0;
         mi_neg_ff   <= 1'b0;
         span_ff     <= '0;
         mi_mag_ff   <= '0;
         k_ff        <= '0;
      end else begin
         start_x_ff  <= start_x_in;
         start_y_ff  <= start_y_in;
         end_x_ff    <= end_x_in;
         end_y_ff    <= end_y_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         major_x_ff  <= major_x_in;
         step_neg_ff <= step_neg_in;
         mi_neg_ff   <= mi_neg_in;
         span_ff     <= span_in;
         mi_mag_ff   <= mi_mag_in;
         k_ff        <= k_in;
      end
   end

   // Minor numerator: minor span times major offset
   always_ff @(posedge clock) begin
      if (cmd.prod_capture) begin
         prod_ff <= PROD_W'(mi_mag_ff) * PROD_W'(k_ff);
      end
   end

   // Divider operands: fraction uses k << FRACTION_BITS, minor offset uses the product
   always_comb begin
      div_load = cmd.frac_start || cmd.off_start;
      if (cmd.frac_start) begin
         div_rem_init = k_ff >> 1;
         div_num_init = QW'(k_ff[0]) << (QW - 1);
      end else begin
         div_rem_init = prod_ff[PROD_W-1:SPAN_W];
         div_num_init = QW'(prod_ff[SPAN_W-1:0]) << (QW - SPAN_W);
      end
   end

   glps_div #(
      .DW (SPAN_W),
      .QW (QW)
   ) u_div (
      .clock    (clock),
      .load     (div_load),
      .step     (cmd.div_step),
      .divisor  (span_ff),
      .rem_init (div_rem_init),
      .num_init (div_num_init),
      .quotient (div_result)
   );

   // Output register for one result transaction
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_x_ff    <= cur_x_ff;
         rsp_y_ff    <= cur_y_ff;
         rsp_frac_ff <= span_zero ? FRAC_ONE : div_result[FW-1:0];
         rsp_more_ff <= !at_end;
      end
   end

   assign rsp_point_x       = rsp_x_ff;
   assign rsp_point_y       = rsp_y_ff;
   assign rsp_fraction_done = rsp_frac_ff;
   assign rsp_more_points   = rsp_more_ff;

endmodule

`default_nettype wire

### design/grid_line_point_stepper_unit.sv
// Grid line point stepper: walks the grid cells of a straight line, one point per request.
// A load transaction (operation 0) stores two endpoints when it is accepted and gives no result. A
// next transaction (operation 1) returns the current point, the fraction of the major span
// done (unsigned Q1.FRACTION_BITS, exact 1.0 on a zero-length line) and a more-points flag,
// then advances one cell; past the end the last point repeats with the flag clear. Both the
// fraction and the minor coordinate are exact quotients by the major span, rounded to
// nearest with ties to even, produced by one shared restoring divider at one quotient bit
// per cycle. Before the next request is accepted, an interior point runs the fraction division,
// the emit, the product and the minor offset division, the end point only the fraction
// division and the emit, and a zero-length line only the emit. The result sits in an output
// register, so the stepper keeps working on the advance while a result is stalled.
`default_nettype none

module grid_line_point_stepper_unit #(
   parameter int COORD_BITS    = glps_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = glps_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_operation,
   input  wire logic signed [COORD_BITS-1:0]  req_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_end_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]       rsp_point_x,
   output logic signed [COORD_BITS-1:0]       rsp_point_y,
   output logic        [FRACTION_BITS:0]      rsp_fraction_done,
   output logic                               rsp_more_points
);

   localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   glps_pkg::glps_cmd_type    cmd;
   glps_pkg::glps_status_type status;

   glps_ctrl #(
      .FW     (FRACTION_BITS + 1),
      .SPAN_W (COORD_BITS + 1)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .status        (status),
      .cmd           (cmd)
   );

   glps_dp #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .status            (status),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_fraction_done (rsp_fraction_done),
      .rsp_more_points   (rsp_more_points)
   );

   // The end point always reports the whole span done
   a_end_is_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_more_points) |-> (rsp_fraction_done == FRAC_ONE))
      else $error("end point fraction is not 1.0");

   // Progress never passes 1.0
   a_frac_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fraction_done <= FRAC_ONE))
      else $error("fraction done above 1.0");

   // A load transaction completes in its own cycle
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == glps_pkg::OP_LOAD)) |=> !req_stall)
      else $error("stepper busy after a load");

endmodule

`default_nettype wire
